// ===== hdl/ghash_engine_macros.svh =====
// ----------------------------------------------------------------------------
// ghash_engine_macros.svh
// Assertion helpers for the GHASH engine checker.
// ----------------------------------------------------------------------------
`ifndef GHASH_ENGINE_MACROS_SVH
`define GHASH_ENGINE_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define GHE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define GHE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// ghash_pkg
// Types, constants and GF(2^128) helpers for the GHASH engine.
// ----------------------------------------------------------------------------
package ghash_pkg;

  localparam int BLK_W     = 128;               // field element width
  localparam int HALF_W    = 64;
  localparam int BLK_BYTES = 16;
  localparam int CNT_W     = 61;                // byte counters, wrap mod 2^61
  localparam int LEN_SHIFT = 3;                 // bytes to bits
  localparam int DIGIT_W   = 16;                // multiplier bits per cycle
  localparam int STEPS     = BLK_W / DIGIT_W;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int BCNT_W    = 5;

  // x^128 = 1 + x + x^2 + x^7, bit-reflected: lands in the top byte
  localparam logic [BLK_W-1:0] GF_RED = {8'hE1, {(BLK_W-8){1'b0}}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_HASH_KEY_HI = 1'b0,
    REG_HASH_KEY_LO = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_DATA,
    ST_MUL_LEN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [HALF_W-1:0] block_hi;
    logic [HALF_W-1:0] block_lo;
    logic [BCNT_W-1:0] byte_count;
    logic              section;
    logic              last;
  } blk_t;

  typedef struct packed {
    logic [HALF_W-1:0] tag_hi;
    logic [HALF_W-1:0] tag_lo;
  } tag_t;

  // Multiply v by x^n (n up to DIGIT_W) with reduction.
  // Dropped bits fold back at most DIGIT_W-1 places, so one fold is enough.
  function automatic logic [BLK_W-1:0] gf_mulx(input logic [BLK_W-1:0] v,
                                               input int unsigned n);
    logic [BLK_W-1:0] res;
    res = v >> n;
    for (int unsigned k = 0; k < DIGIT_W; k++) begin
      if (k < n && v[k]) begin
        res ^= GF_RED >> (n - 1 - k);
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/ghash_mul.sv =====
// ----------------------------------------------------------------------------
// ghash_mul
// Digit-serial GF(2^128) multiplier: 16 operand bits per cycle.
// ----------------------------------------------------------------------------
module ghash_mul import ghash_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [BLK_W-1:0] op,
  input  logic [BLK_W-1:0] key,
  output logic             done,
  output logic [BLK_W-1:0] prod
);

  logic [BLK_W-1:0]   a_sr;   // operand, consumed from the top
  logic [BLK_W-1:0]   v;      // key times x^(bits consumed)
  logic [BLK_W-1:0]   z;      // running product
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic [DIGIT_W-1:0] digit;
  logic [BLK_W-1:0]   pp;

  // Partial product of one digit against the current key multiple
  always_comb begin
    digit = a_sr[BLK_W-1 -: DIGIT_W];
    pp    = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (digit[DIGIT_W-1-j]) begin
        pp ^= gf_mulx(v, j);
      end
    end
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_sr <= op;
      v    <= key;
      z    <= '0;
    end else if (busy) begin
      a_sr <= a_sr << DIGIT_W;
      v    <= gf_mulx(v, DIGIT_W);
      z    <= z ^ pp;
    end
  end

  assign prod = z;

endmodule

// ===== hdl/ghash_engine.sv =====
// ----------------------------------------------------------------------------
// ghash_engine
// GCM GHASH over additional data and ciphertext, tag on the last block.
// ----------------------------------------------------------------------------
// Each accepted block with a nonzero byte count is XORed into the
// accumulator and multiplied by H in a digit-serial GF(2^128) unit that
// handles 16 bits per cycle, and the engine stays busy through the load,
// the multiply and its completion; a block with a byte count of zero and
// no last flag is taken without a multiply. A last transaction adds a
// multiply of the length block, started in the cycle the data multiply
// completes (or on acceptance of an empty last), then the tag is posted
// from the emit state. The tag sits in an output register, so the next
// message can start while the tag waits to be taken; a second tag holds
// the engine in its emit state until the first one is taken. Counters and
// accumulator clear when the tag is posted; the key registers are kept.
// ----------------------------------------------------------------------------
module ghash_engine import ghash_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // key configuration
  input  logic              wr_en,
  input  reg_idx_t          wr_index,
  input  logic [HALF_W-1:0] wr_data,
  // block input
  input  logic              blk_valid,
  output logic              blk_ready,
  input  blk_t              blk,
  // tag output
  output logic              tag_valid,
  input  logic              tag_ready,
  output tag_t              tag
);

  state_t            state, state_next;
  logic [BLK_W-1:0]  hash_key;
  logic [BLK_W-1:0]  acc;
  logic [CNT_W-1:0]  aad_bytes;
  logic [CNT_W-1:0]  text_bytes;
  logic              last_q;

  logic              accept;
  logic              emit;
  logic              mul_start;
  logic [BLK_W-1:0]  mul_op;
  logic              mul_done;
  logic [BLK_W-1:0]  mul_prod;
  logic [BCNT_W-1:0] n_sat;
  logic              has_data;
  logic [BLK_W-1:0]  blk_vec;
  logic [BLK_W-1:0]  masked;
  logic [BLK_W-1:0]  len_blk;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_key <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_HASH_KEY_HI: hash_key[BLK_W-1 -: HALF_W] <= wr_data;
        REG_HASH_KEY_LO: hash_key[HALF_W-1:0]        <= wr_data;
        default: ;
      endcase
    end
  end

  // Byte count saturation, padding and length block
  always_comb begin
    n_sat    = (blk.byte_count > BCNT_W'(BLK_BYTES)) ? BCNT_W'(BLK_BYTES) : blk.byte_count;
    has_data = (n_sat != '0);
    blk_vec  = {blk.block_hi, blk.block_lo};
    masked   = '0;
    for (int b = 0; b < BLK_BYTES; b++) begin
      if (BCNT_W'(b) < n_sat) begin
        masked[BLK_W-1-8*b -: 8] = blk_vec[BLK_W-1-8*b -: 8];
      end
    end
    len_blk = {aad_bytes, {LEN_SHIFT{1'b0}}, text_bytes, {LEN_SHIFT{1'b0}}};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (blk_valid) begin
          if (has_data)      state_next = ST_MUL_DATA;
          else if (blk.last) state_next = ST_MUL_LEN;
        end
      end
      ST_MUL_DATA: begin
        if (mul_done) state_next = last_q ? ST_MUL_LEN : ST_IDLE;
      end
      ST_MUL_LEN: begin
        if (mul_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!tag_valid || tag_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    blk_ready = 1'b0;
    mul_start = 1'b0;
    mul_op    = acc ^ masked;
    emit      = 1'b0;
    case (state)
      ST_IDLE: begin
        blk_ready = 1'b1;
        if (blk_valid) begin
          if (has_data) begin
            mul_start = 1'b1;
          end else if (blk.last) begin
            mul_start = 1'b1;
            mul_op    = acc ^ len_blk;
          end
        end
      end
      ST_MUL_DATA: begin
        mul_op = mul_prod ^ len_blk;
        if (mul_done && last_q) mul_start = 1'b1;
      end
      ST_EMIT: begin
        emit = !tag_valid || tag_ready;
      end
      default: ;
    endcase
  end

  assign accept = blk_valid && blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Message state: accumulator, byte counters, last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      aad_bytes  <= '0;
      text_bytes <= '0;
      last_q     <= 1'b0;
    end else if (emit) begin
      acc        <= '0;
      aad_bytes  <= '0;
      text_bytes <= '0;
    end else begin
      if (accept) begin
        last_q <= blk.last;
        if (has_data) begin
          if (blk.section) text_bytes <= text_bytes + CNT_W'(n_sat);
          else             aad_bytes  <= aad_bytes + CNT_W'(n_sat);
        end
      end
      if (mul_done) begin
        acc <= mul_prod;
      end
    end
  end

  // Tag output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (emit) begin
      tag_valid <= 1'b1;
    end else if (tag_ready) begin
      tag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tag <= acc;
    end
  end

  ghash_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op    (mul_op),
    .key   (hash_key),
    .done  (mul_done),
    .prod  (mul_prod)
  );

endmodule

// ===== hdl/ghash_chk.sv =====
// ----------------------------------------------------------------------------
// ghash_chk
// Port-level checks for the GHASH engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "ghash_engine_macros.svh"

module ghash_chk import ghash_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              wr_en,
  input reg_idx_t          wr_index,
  input logic [HALF_W-1:0] wr_data,
  input logic              blk_valid,
  input logic              blk_ready,
  input blk_t              blk,
  input logic              tag_valid,
  input logic              tag_ready,
  input tag_t              tag
);

  logic       blk_xact;
  logic       blk_work;
  logic       tag_stall;
  logic       wr_unused;
  logic       key_quiet;
  logic [7:0] rdy_hist;     // blk_ready history, newest sample in bit 0
  logic       len_ran;

  assign blk_xact  = blk_valid && blk_ready;
  assign blk_work  = blk_xact && (blk.last || (blk.byte_count != '0));
  assign tag_stall = tag_valid && !tag_ready;
  assign wr_unused = wr_en && (wr_index == REG_HASH_KEY_HI) && (wr_data == '0);
  assign key_quiet = wr_unused && !tag_valid && blk_ready && !blk_valid;

  // Ready history: busy in both end samples means a length multiply ran
  always_ff @(posedge clk) begin
    rdy_hist <= {rdy_hist[6:0], blk_ready};
  end

  assign len_ran = !rdy_hist[0] && !rdy_hist[7];

  // A stalled tag stays posted and unchanged
  `GHE_ASSERT_NEXT(a_tag_hold, clk, rst, tag_stall, tag_valid && $stable(tag), "tag not held")

  // A transaction that starts a multiply makes the engine busy
  `GHE_ASSERT_NEXT(a_busy_after_work, clk, rst, blk_work, !blk_ready, "not busy after work")

  // A tag is posted only after a length multiply has run
  `GHE_ASSERT_SAME(a_tag_after_len, clk, rst, $rose(tag_valid), len_ran, "tag too early")

  // A zero write to the high key half while idle never produces a tag
  `GHE_ASSERT_NEXT(a_key_no_tag, clk, rst, key_quiet, !tag_valid, "tag from key write")

endmodule

bind ghash_engine ghash_chk u_chk (.*);
